// ----- hdl/buzzer_beep_pattern_sequencer_macros.svh -----
// Assertion helpers shared by the sequencer modules.
`ifndef BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BBPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BBPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/bbps_pkg.sv -----
package bbps_pkg;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_PRESET = 2'd1,
		MODE_CUSTOM = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PRESET_CLICK    = 2'd0,
		PRESET_LIMIT    = 2'd1,
		PRESET_ALARM    = 2'd2,
		PRESET_POWER_ON = 2'd3
	} preset_t;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MUTE          = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_REPEATS = 1'b1;

	localparam logic [7:0]  ALARM_REPEATS_RESET = 8'd3;
	localparam logic [15:0] CLICK_ON_TICKS      = 16'd45;
	localparam logic [15:0] LIMIT_TICKS         = 16'd60;
	localparam logic [15:0] ALARM_TICKS         = 16'd100;
	localparam logic [15:0] POWER_ON_TICKS      = 16'd300;
	localparam logic [15:0] PRESET_FREQ         = 16'd2000;
	localparam logic [7:0]  PRESET_VOLUME       = 8'd50;

	typedef struct packed {
		mode_t       mode;
		preset_t     preset;
		logic [15:0] custom_freq;
		logic [7:0]  custom_volume;
		logic [15:0] custom_on_ms;
		logic [15:0] custom_off_ms;
		logic [7:0]  custom_repeats;
	} item_t;

	typedef struct packed {
		logic        tone_on;
		logic [15:0] tone_freq;
		logic [7:0]  tone_volume;
		logic        sequence_active;
	} result_t;

	typedef struct packed {
		logic [15:0] held_freq;
		logic [7:0]  held_volume;
		logic [15:0] on_length;
		logic [15:0] off_length;
		logic [15:0] phase_timer;
		logic [7:0]  repeats_left;
		logic        sounding;
	} seq_state_t;

	// Handshake between the input register and the result register.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

// ----- hdl/bbps_in_stage.sv -----
module bbps_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bbps_pkg::item_t    item,
	input  logic               out_free,
	output bbps_pkg::stage_ctl_t ctl,
	output bbps_pkg::item_t    item_s1
);

	logic valid_s1;

	assign ctl.valid   = valid_s1;
	assign ctl.advance = valid_s1 & out_free;
	assign in_ready    = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ----- hdl/bbps_update.sv -----
`include "buzzer_beep_pattern_sequencer_macros.svh"

module bbps_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  bbps_pkg::item_t                    item_s1,
	input  logic                               cfg_valid,
	input  logic [bbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [7:0]                         cfg_data,
	output bbps_pkg::result_t                  result
);

	logic                  mute_q;
	logic [7:0]            alarm_repeats_q;
	bbps_pkg::seq_state_t  st_q;
	bbps_pkg::seq_state_t  st_nxt;

	logic        start;
	logic [15:0] ld_freq;
	logic [7:0]  ld_volume;
	logic [15:0] ld_on;
	logic [15:0] ld_off;
	logic [7:0]  ld_repeats;
	logic [7:0]  repeats_dec;
	logic        click_busy;

	assign repeats_dec = st_q.repeats_left - 8'd1;
	// A click that is already sounding is not restarted.
	assign click_busy  = st_q.sounding && (st_q.repeats_left == 8'd1) &&
		(st_q.off_length == 16'd0) && (st_q.on_length == bbps_pkg::CLICK_ON_TICKS);

	always_comb begin
		st_nxt     = st_q;
		start      = 1'b0;
		ld_freq    = bbps_pkg::PRESET_FREQ;
		ld_volume  = bbps_pkg::PRESET_VOLUME;
		ld_on      = bbps_pkg::CLICK_ON_TICKS;
		ld_off     = 16'd0;
		ld_repeats = 8'd1;
		case (item_s1.mode)
			bbps_pkg::MODE_TICK: begin
				if (st_q.repeats_left != 8'd0) begin
					if (st_q.phase_timer != 16'd0) begin
						st_nxt.phase_timer = st_q.phase_timer - 16'd1;
					end else if (st_q.sounding) begin
						st_nxt.sounding    = 1'b0;
						st_nxt.phase_timer = st_q.off_length;
						if (st_q.off_length == 16'd0) begin
							st_nxt.repeats_left = 8'd0;
						end
					end else begin
						st_nxt.repeats_left = repeats_dec;
						if (repeats_dec != 8'd0) begin
							st_nxt.sounding    = 1'b1;
							st_nxt.phase_timer = st_q.on_length;
						end
					end
				end
			end
			bbps_pkg::MODE_PRESET: begin
				case (item_s1.preset)
					bbps_pkg::PRESET_CLICK: begin
						start = ~click_busy;
					end
					bbps_pkg::PRESET_LIMIT: begin
						start  = 1'b1;
						ld_on  = bbps_pkg::LIMIT_TICKS;
						ld_off = bbps_pkg::LIMIT_TICKS;
					end
					bbps_pkg::PRESET_ALARM: begin
						start      = 1'b1;
						ld_on      = bbps_pkg::ALARM_TICKS;
						ld_off     = bbps_pkg::ALARM_TICKS;
						ld_repeats = alarm_repeats_q;
					end
					default: begin
						start = 1'b1;
						ld_on = bbps_pkg::POWER_ON_TICKS;
					end
				endcase
			end
			bbps_pkg::MODE_CUSTOM: begin
				start      = 1'b1;
				ld_freq    = item_s1.custom_freq;
				ld_volume  = item_s1.custom_volume;
				ld_on      = item_s1.custom_on_ms;
				ld_off     = item_s1.custom_off_ms;
				ld_repeats = item_s1.custom_repeats;
			end
			default: begin
			end
		endcase
		if (start && !mute_q) begin
			st_nxt.held_freq    = ld_freq;
			st_nxt.held_volume  = ld_volume;
			st_nxt.on_length    = ld_on;
			st_nxt.off_length   = ld_off;
			st_nxt.repeats_left = ld_repeats;
			st_nxt.phase_timer  = ld_on;
			st_nxt.sounding     = 1'b1;
		end
	end

	assign result.tone_on         = st_nxt.sounding;
	assign result.tone_freq       = st_nxt.held_freq;
	assign result.tone_volume     = st_nxt.held_volume;
	assign result.sequence_active = (st_nxt.repeats_left != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q          <= 1'b0;
			alarm_repeats_q <= bbps_pkg::ALARM_REPEATS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == bbps_pkg::CFG_MUTE) begin
				mute_q <= cfg_data[0];
			end else begin
				alarm_repeats_q <= cfg_data;
			end
		end
	end

	// A tick with no repeats left leaves the tone state alone.
	`BBPS_ASSERT_NEXT(a_idle_tick_stable, clk, arst_n, advance && (item_s1.mode == bbps_pkg::MODE_TICK) && (st_q.repeats_left == 8'd0), $stable(st_q))
	// Only a tick can silence the tone.
	`BBPS_ASSERT_NEXT(a_silence_by_tick, clk, arst_n, st_q.sounding && !(advance && (item_s1.mode == bbps_pkg::MODE_TICK)), st_q.sounding)
	// A muted start does not reprogram the tone.
	`BBPS_ASSERT_NEXT(a_mute_holds_freq, clk, arst_n, advance && mute_q && (item_s1.mode != bbps_pkg::MODE_TICK), $stable(st_q.held_freq) && $stable(st_q.on_length))

endmodule

// ----- hdl/bbps_out_stage.sv -----
module bbps_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbps_pkg::stage_ctl_t ctl,
	input  bbps_pkg::result_t    result,
	output logic                 out_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bbps_pkg::result_t    result_s2
);

	logic valid_s2;

	assign out_free  = ~valid_s2 | out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= ctl.advance;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			result_s2 <= result;
		end
	end

endmodule

// ----- hdl/buzzer_beep_pattern_sequencer.sv -----
// A result is offered from the result register, which holds the updated tone state;
// an input transfer passes through the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls the result register.
// Configuration writes are taken in any cycle (cfg_ready is always high).
// Reset clears the tone state, mute to 0, alarm_repeats to 3, and both stages empty.
`include "buzzer_beep_pattern_sequencer_macros.svh"

module buzzer_beep_pattern_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic [1:0]                       preset,
	input  logic [15:0]                      custom_freq,
	input  logic [7:0]                       custom_volume,
	input  logic [15:0]                      custom_on_ms,
	input  logic [15:0]                      custom_off_ms,
	input  logic [7:0]                       custom_repeats,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             tone_on,
	output logic [15:0]                      tone_freq,
	output logic [7:0]                       tone_volume,
	output logic                             sequence_active,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);

	bbps_pkg::item_t      item;
	bbps_pkg::item_t      item_s1;
	bbps_pkg::stage_ctl_t ctl;
	bbps_pkg::result_t    result;
	bbps_pkg::result_t    result_s2;
	logic                 out_free;

	assign cfg_ready = 1'b1;

	assign item.mode           = bbps_pkg::mode_t'(mode);
	assign item.preset         = bbps_pkg::preset_t'(preset);
	assign item.custom_freq    = custom_freq;
	assign item.custom_volume  = custom_volume;
	assign item.custom_on_ms   = custom_on_ms;
	assign item.custom_off_ms  = custom_off_ms;
	assign item.custom_repeats = custom_repeats;

	bbps_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.out_free (out_free),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	bbps_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (ctl.advance),
		.item_s1   (item_s1),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	bbps_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_s2 (result_s2)
	);

	assign tone_on         = result_s2.tone_on;
	assign tone_freq       = result_s2.tone_freq;
	assign tone_volume     = result_s2.tone_volume;
	assign sequence_active = result_s2.sequence_active;

	// Input is only refused while the input register holds an item that cannot move on.
	`BBPS_ASSERT_SAME(a_ready_only_when_blocked, clk, arst_n, !in_ready, ctl.valid && out_valid && !out_ready)

endmodule
